// File: sv/tlb_write_probe_read_macros.svh
// Assertion macros shared by the TLB store RTL.
// Define ASSERT_OFF to compile the macros to nothing.
`ifndef TLB_WRITE_PROBE_READ_MACROS_SVH
`define TLB_WRITE_PROBE_READ_MACROS_SVH

`ifndef ASSERT_OFF
`define TWPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TWPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TWPR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TWPR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/tlbwpr_pkg.sv
// Types, constants and codes of the joint TLB store.
// No dependencies; every other RTL file imports this package.
package tlbwpr_pkg;

    localparam int ENTRIES = 48;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [31:0] MISS_WORD   = 32'h8000_0000;
    localparam logic [31:0] HI_RSV_MASK = 32'h0000_1f00;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [31:0] page_mask;
        logic [31:0] entry_hi;
        logic [31:0] entry_lo0;
        logic [31:0] entry_lo1;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_idx   addr;
        t_entry wdata;
    } t_store_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PROBE
    } t_state;

endpackage

// File: sv/tlb_write_probe_read.sv
// Joint TLB store with write, probe and read operations. An item is taken when start is high
// and busy is low; its result appears for one cycle with o_done, and cannot be held off. A write,
// an out-of-range read or an unused operation gives its result in the cycle after it is taken; a
// read passes through S_READ before its result is registered; a probe stops at the first hit or
// after the last entry. The entry memory has a single registered read port, which the probe
// walks one entry per cycle through one shared compare unit. The store is all zero after reset.
// Depends on tlbwpr_pkg, tlbwpr_store, tlbwpr_cmp and tlb_write_probe_read_macros.svh.
`include "tlb_write_probe_read_macros.svh"

module tlb_write_probe_read
    import tlbwpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_entry_index,
    input  logic [31:0] i_page_mask_in,
    input  logic [31:0] i_entry_hi_in,
    input  logic [31:0] i_entry_lo0_in,
    input  logic [31:0] i_entry_lo1_in,
    output logic        o_done,
    output logic [31:0] o_index_word,
    output logic [31:0] o_page_mask_out,
    output logic [31:0] o_entry_hi_out,
    output logic [31:0] o_entry_lo0_out,
    output logic [31:0] o_entry_lo1_out,
    output logic        o_ignored
);

    t_state      r_state, n_state;
    t_idx        r_idx, n_idx;
    logic [31:0] r_key, n_key;
    logic        r_done, n_done;
    logic [31:0] r_index_word, n_index_word;
    logic [31:0] r_page_mask, n_page_mask;
    logic [31:0] r_entry_hi, n_entry_hi;
    logic [31:0] r_entry_lo0, n_entry_lo0;
    logic [31:0] r_entry_lo1, n_entry_lo1;
    logic        r_ignored, n_ignored;

    t_store_req  store_req;
    t_entry      rdata;
    logic        hit;
    logic        accept;
    logic        in_range;
    logic        last_entry;

    tlbwpr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rdata (rdata)
    );

    tlbwpr_cmp u_cmp (
        .i_entry (rdata),
        .i_key   (r_key),
        .o_hit   (hit)
    );

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign in_range   = ({1'b0, i_entry_index} < 7'(ENTRIES));
    assign last_entry = (r_idx == IDX_W'(ENTRIES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_PROBE) begin
                        n_state = S_PROBE;
                    end else if (i_op == OP_READ && in_range) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_PROBE: begin
                if (hit || last_entry) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result controls.
    always_comb begin
        n_idx             = r_idx;
        n_key             = r_key;
        n_done            = 1'b0;
        n_index_word      = '0;
        n_page_mask       = '0;
        n_entry_hi        = '0;
        n_entry_lo0       = '0;
        n_entry_lo1       = '0;
        n_ignored         = 1'b0;
        store_req.we      = 1'b0;
        store_req.addr    = i_entry_index[IDX_W-1:0];
        store_req.wdata   = '{i_page_mask_in, i_entry_hi_in, i_entry_lo0_in, i_entry_lo1_in};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PROBE: begin
                            n_idx          = '0;
                            n_key          = i_entry_hi_in;
                            store_req.addr = '0;
                        end
                        OP_WRITE: begin
                            store_req.we = in_range;
                            n_done       = 1'b1;
                            n_ignored    = !in_range;
                        end
                        OP_READ: begin
                            n_done    = !in_range;
                            n_ignored = !in_range;
                        end
                        default: begin
                            n_done    = 1'b1;
                            n_ignored = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done      = 1'b1;
                n_page_mask = rdata.page_mask;
                n_entry_hi  = rdata.entry_hi & ~(rdata.page_mask | HI_RSV_MASK);
                n_entry_lo0 = {rdata.entry_lo0[31:1], rdata.entry_hi[12]};
                n_entry_lo1 = {rdata.entry_lo1[31:1], rdata.entry_hi[12]};
            end
            S_PROBE: begin
                // The memory returns the entry at r_idx; fetch the following one meanwhile.
                store_req.addr = r_idx + 1'b1;
                n_idx          = r_idx + 1'b1;
                if (hit) begin
                    n_done       = 1'b1;
                    n_index_word = 32'(r_idx);
                end else if (last_entry) begin
                    n_done       = 1'b1;
                    n_index_word = MISS_WORD;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_key        <= n_key;
        r_index_word <= n_index_word;
        r_page_mask  <= n_page_mask;
        r_entry_hi   <= n_entry_hi;
        r_entry_lo0  <= n_entry_lo0;
        r_entry_lo1  <= n_entry_lo1;
        r_ignored    <= n_ignored;
    end

    assign o_done          = r_done;
    assign o_index_word    = r_index_word;
    assign o_page_mask_out = r_page_mask;
    assign o_entry_hi_out  = r_entry_hi;
    assign o_entry_lo0_out = r_entry_lo0;
    assign o_entry_lo1_out = r_entry_lo1;
    assign o_ignored       = r_ignored;

    `TWPR_ASSERT_NXT(a_probe_start, i_clk, i_rst_n, accept && i_op == OP_PROBE,
        r_state == S_PROBE && r_idx == '0)
    `TWPR_ASSERT_NXT(a_probe_walk, i_clk, i_rst_n, r_state == S_PROBE && !hit && !last_entry,
        r_state == S_PROBE && r_idx == $past(r_idx) + 1'b1)
    `TWPR_ASSERT_NXT(a_read_done, i_clk, i_rst_n, r_state == S_READ,
        r_done && r_state == S_IDLE)
    `TWPR_ASSERT_IMP(a_ignored_clean, i_clk, i_rst_n, r_done && r_ignored,
        r_index_word == '0 && r_page_mask == '0 && r_entry_hi == '0)

endmodule

// File: sv/tlbwpr_store.sv
// Entry memory of the TLB with one shared write/read address and registered read data.
// Depends on tlbwpr_pkg. Per-entry valid bits make never-written entries read as zero.
module tlbwpr_store
    import tlbwpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_entry     o_rdata
);

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_entry             r_rdata;
    logic               r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_req.addr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// File: sv/tlbwpr_cmp.sv
// Probe compare unit: tests one stored entry against the probe key.
// Depends on tlbwpr_pkg.
module tlbwpr_cmp
    import tlbwpr_pkg::*;
(
    input  t_entry      i_entry,
    input  logic [31:0] i_key,
    output logic        o_hit
);

    logic [18:0] mask;
    logic        vpn_eq;
    logic        is_global;
    logic        asid_eq;

    always_comb begin
        mask      = {7'd0, i_entry.page_mask[24:13]};
        vpn_eq    = ((i_entry.entry_hi[31:13] & ~mask) == (i_key[31:13] & ~mask));
        is_global = i_entry.entry_lo0[0] & i_entry.entry_lo1[0];
        asid_eq   = (i_entry.entry_hi[7:0] == i_key[7:0]);
        o_hit     = vpn_eq && (is_global || asid_eq);
    end

endmodule
